### hw/rtl/b64enc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64enc_pkg
// shared types, constants and the sextet to ascii mapping of the encoder
// ----------------------------------------------------------------------------
package b64enc_pkg;

  localparam logic [7:0] PadChar = 8'h3D;

  localparam logic [1:0] CntEmpty = 2'd0;
  localparam logic [1:0] CntOne   = 2'd1;
  localparam logic [1:0] CntTwo   = 2'd2;
  localparam logic [1:0] CntThree = 2'd3;

  localparam logic [1:0] IdxLast = 2'd3;

  typedef struct packed {
    logic [23:0] bits;    // first byte in bits 23..16
    logic [1:0]  nbytes;  // 1..3
    logic        last;
  } group_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } q_rd_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v};
    if (v < 6'd26) begin
      c = w + 8'd65;
    end else if (v < 6'd52) begin
      c = w + 8'd71;
    end else if (v < 6'd62) begin
      c = w - 8'd4;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/b64enc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64enc_front
// collects input bytes into groups of up to three and pushes closed groups
// ----------------------------------------------------------------------------
module b64enc_front import b64enc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] s_axis_tdata,   // data_byte[7:0]
  input  wire logic       s_axis_tlast,   // final_byte
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  output group_t          grp_o,
  output q_wr_t           wr_o,
  input  wire logic       full_i
);

  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] held_q, held_d;
  logic        accept;
  logic        emit;

  assign s_axis_tready = !full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cnt_d       = cnt_q;
    held_d      = held_q;
    emit        = 1'b0;
    grp_o       = '0;
    case (cnt_q)
      CntTwo: begin
        emit        = 1'b1;
        grp_o.bits  = {held_q, s_axis_tdata};
        grp_o.nbytes = 2'd3;
        grp_o.last  = s_axis_tlast;
        cnt_d       = CntEmpty;
        held_d      = '0;
      end
      CntOne: begin
        if (s_axis_tlast) begin
          emit         = 1'b1;
          grp_o.bits   = {held_q[15:8], s_axis_tdata, 8'h00};
          grp_o.nbytes = 2'd2;
          grp_o.last   = 1'b1;
          cnt_d        = CntEmpty;
          held_d       = '0;
        end else begin
          cnt_d  = CntTwo;
          held_d = {held_q[15:8], s_axis_tdata};
        end
      end
      default: begin
        if (s_axis_tlast) begin
          emit         = 1'b1;
          grp_o.bits   = {s_axis_tdata, 16'h0000};
          grp_o.nbytes = 2'd1;
          grp_o.last   = 1'b1;
          cnt_d        = CntEmpty;
          held_d       = '0;
        end else begin
          cnt_d  = CntOne;
          held_d = {s_axis_tdata, 8'h00};
        end
      end
    endcase
  end

  assign wr_o.push = accept && emit;
  assign wr_o.full = full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= CntEmpty;
      held_q <= '0;
    end else if (accept) begin
      cnt_q  <= cnt_d;
      held_q <= held_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != CntThree) else $error("pending count reached three");

endmodule
`default_nettype wire

### hw/rtl/b64enc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64enc_queue
// two-entry queue of closed groups between front and back
// ----------------------------------------------------------------------------
module b64enc_queue import b64enc_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire q_wr_t  wr_i,
  input  wire group_t grp_i,
  output logic        full_o,
  input  wire q_rd_t  rd_i,
  output group_t      grp_o,
  output logic        empty_o
);

  group_t     mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign do_push = wr_i.push && !full_o;
  assign do_pop  = rd_i.pop && !empty_o;
  assign grp_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= grp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= !wptr_q;
      end
      if (do_pop) begin
        rptr_q <= !rptr_q;
      end
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.push |-> !full_o) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i.pop |-> !empty_o) else $error("pop from empty queue");
  a_count_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd1) == (wptr_q != rptr_q)) else $error("queue pointers out of step");

endmodule
`default_nettype wire

### hw/rtl/b64enc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64enc_back
// takes groups from the queue and sends four characters for each
// ----------------------------------------------------------------------------
module b64enc_back import b64enc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire group_t     grp_i,
  input  wire logic       empty_i,
  output q_rd_t           rd_o,
  output logic [7:0]      m_axis_tdata,   // out_char[7:0]
  output logic            m_axis_tlast,   // end_of_message
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready
);

  logic       busy_q;
  logic [1:0] idx_q;
  group_t     grp_q;
  logic       done;
  logic       load;

  assign done  = m_axis_tvalid && m_axis_tready;
  assign load  = !empty_i && (!busy_q || (done && idx_q == IdxLast));
  assign rd_o.pop   = load;
  assign rd_o.empty = empty_i;

  assign m_axis_tvalid = busy_q;
  assign m_axis_tlast  = grp_q.last && (idx_q == IdxLast);

  always_comb begin
    case (idx_q)
      2'd0: m_axis_tdata = sextet_char(grp_q.bits[23:18]);
      2'd1: m_axis_tdata = sextet_char(grp_q.bits[17:12]);
      2'd2: m_axis_tdata = (grp_q.nbytes > 2'd1) ? sextet_char(grp_q.bits[11:6]) : PadChar;
      default: m_axis_tdata = (grp_q.nbytes > 2'd2) ? sextet_char(grp_q.bits[5:0]) : PadChar;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      grp_q <= grp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (load) begin
      busy_q <= 1'b1;
      idx_q  <= 2'd0;
    end else if (done) begin
      idx_q <= idx_q + 2'd1;
      if (idx_q == IdxLast) begin
        busy_q <= 1'b0;
      end
    end
  end

  a_idle_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> idx_q == 2'd0) else $error("char index not cleared when idle");
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> idx_q == IdxLast) else $error("last flag off group end");

endmodule
`default_nettype wire

### hw/rtl/base64_stream_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_encoder
// byte stream to base64 characters, standard alphabet with '=' padding
// ----------------------------------------------------------------------------
// a closed group is queued, then loaded into the serializer register, which drives
//   its first character; a busy serializer loads only on its last handshake
// each group leaves as four characters on the one-character output channel
// a two-entry group queue lets input run ahead while characters drain
// reset: asynchronous active low, clears pending bytes, queue and serializer
module base64_stream_encoder import b64enc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] s_axis_tdata,   // data_byte[7:0]
  input  wire logic       s_axis_tlast,   // final_byte
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  output logic [7:0]      m_axis_tdata,   // out_char[7:0]
  output logic            m_axis_tlast,   // end_of_message
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready
);

  group_t wr_grp, rd_grp;
  q_wr_t  wr;
  q_rd_t  rd;
  logic   full, empty;

  b64enc_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tdata,
    .s_axis_tlast,
    .s_axis_tvalid,
    .s_axis_tready,
    .grp_o  (wr_grp),
    .wr_o   (wr),
    .full_i (full)
  );

  b64enc_queue u_queue (
    .clk_i,
    .rst_ni,
    .wr_i    (wr),
    .grp_i   (wr_grp),
    .full_o  (full),
    .rd_i    (rd),
    .grp_o   (rd_grp),
    .empty_o (empty)
  );

  b64enc_back u_back (
    .clk_i,
    .rst_ni,
    .grp_i   (rd_grp),
    .empty_i (empty),
    .rd_o    (rd),
    .m_axis_tdata,
    .m_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready
  );

endmodule
`default_nettype wire

### bench/b64_char_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// b64_char_checker
// watches the byte and character streams of the base64 encoder, keeps its own
// copy of the held bytes, builds the four characters that each closed group
// must give and compares every character transaction against the oldest one
// ----------------------------------------------------------------------------
module b64_char_checker import b64enc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] s_tdata_i,
  input  logic       s_tlast_i,
  input  logic       s_tvalid_i,
  input  logic       s_tready_i,
  input  logic [7:0] m_tdata_i,
  input  logic       m_tlast_i,
  input  logic       m_tvalid_i,
  input  logic       m_tready_i,
  output int         fail_count_o,
  output int         pending_o
);

  localparam logic [511:0] B64Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] code;
    logic       eom;
  } char_beat_t;

  char_beat_t  expected_chars[$];
  char_beat_t  due;
  logic [15:0] held_bytes;
  logic [1:0]  held_count;
  int          fails;

  function automatic logic [7:0] b64_symbol(logic [5:0] v);
    return B64Alphabet[8 * (63 - v) +: 8];
  endfunction

  function automatic void queue_group(logic [23:0] grp, int nbytes, logic fin);
    expected_chars.push_back('{b64_symbol(grp[23:18]), 1'b0});
    expected_chars.push_back('{b64_symbol(grp[17:12]), 1'b0});
    expected_chars.push_back('{(nbytes > 1) ? b64_symbol(grp[11:6]) : PadChar, 1'b0});
    expected_chars.push_back('{(nbytes > 2) ? b64_symbol(grp[5:0]) : PadChar, fin});
  endfunction

  // a held count of three would act as empty
  function automatic void absorb_byte(logic [7:0] b, logic fin);
    if (held_count == CntTwo) begin
      queue_group({held_bytes, b}, 3, fin);
      held_bytes = '0;
      held_count = CntEmpty;
    end else if (held_count == CntOne) begin
      if (fin) begin
        queue_group({held_bytes[15:8], b, 8'h00}, 2, 1'b1);
        held_bytes = '0;
        held_count = CntEmpty;
      end else begin
        held_bytes[7:0] = b;
        held_count = CntTwo;
      end
    end else if (fin) begin
      queue_group({b, 16'h0000}, 1, 1'b1);
      held_bytes = '0;
      held_count = CntEmpty;
    end else begin
      held_bytes = {b, 8'h00};
      held_count = CntOne;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_bytes = '0;
      held_count = CntEmpty;
      fails = 0;
      expected_chars.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character transaction: out_char %h, end_of_message %b",
                 m_tdata_i, m_tlast_i);
          fails++;
        end else begin
          due = expected_chars.pop_front();
          if (m_tdata_i !== due.code) begin
            $error("out_char mismatch: expected %h, actual %h", due.code, m_tdata_i);
            fails++;
          end
          if (m_tlast_i !== due.eom) begin
            $error("end_of_message mismatch: expected %b, actual %b", due.eom, m_tlast_i);
            fails++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        absorb_byte(s_tdata_i, s_tlast_i);
      end
      fail_count_o <= fails;
      pending_o <= expected_chars.size();
    end
  end

endmodule

### bench/tb_base64_stream_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_base64_stream_encoder
// feeds byte messages into the base64 encoder, first a handful of directed
// edge cases (zero and all-ones bytes, the '+' and '/' symbols, one-, two- and
// three-byte final groups) and then random messages of random length, with
// random gaps on the input and random stalls on the output, both off for a
// steady run of messages; the checker predicts and compares every character
// ----------------------------------------------------------------------------
module tb_base64_stream_encoder;

  localparam int ByteTarget = 160;
  localparam int IdleLimit  = 2000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic [7:0] s_axis_tdata = '0;
  logic       s_axis_tlast = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;

  int fail_count;
  int pending_chars;
  int idle_cycles = 0;
  int bytes_sent = 0;
  int messages_sent = 0;
  bit steady = 1'b0;

  always #6 clk_i = ~clk_i;

  base64_stream_encoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  b64_char_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tdata_i    (s_axis_tdata),
    .s_tlast_i    (s_axis_tlast),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .fail_count_o (fail_count),
    .pending_o    (pending_chars)
  );

  // character sink with random stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 25);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no transaction for %0d cycles", IdleLimit);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic fin);
    if (!steady) begin
      while ($urandom_range(0, 99) < 25) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_message(logic [7:0] msg[$]);
    foreach (msg[i]) begin
      send_byte(msg[i], i == msg.size() - 1);
    end
    messages_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_chars != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] msg[$];
    int len;
    int n;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed edge cases
    send_message('{8'h00});
    send_message('{8'hFF});
    send_message('{8'hFB, 8'hFF});
    send_message('{8'hAA, 8'h55, 8'h00});
    send_message('{8'h55, 8'hAA, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h80});
    send_message('{8'h01, 8'h02, 8'h03, 8'h04, 8'h05});

    // random messages, mostly short, some longer
    n = 0;
    while (bytes_sent < ByteTarget) begin
      msg.delete();
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 16) : $urandom_range(1, 3);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 7))
          0:       msg.push_back(8'h00);
          1:       msg.push_back(8'hFF);
          default: msg.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      steady = (n >= 8 && n < 15);
      send_message(msg);
      if (n == 5) begin
        wait_drained();
      end
      n++;
    end
    steady = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("covered %0d messages, %0d bytes: full groups, padded one- and two-byte",
             messages_sent, bytes_sent);
    $display("final groups, edge byte values, input gaps and output stalls");
    if (fail_count == 0 && pending_chars == 0) begin
      $display("TEST PASSED");
    end else begin
      if (pending_chars != 0) begin
        $error("%0d expected characters never arrived", pending_chars);
      end
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/b64enc_pkg.sv
hw/rtl/b64enc_front.sv
hw/rtl/b64enc_queue.sv
hw/rtl/b64enc_back.sv
hw/rtl/base64_stream_encoder.sv
bench/b64_char_checker.sv
bench/tb_base64_stream_encoder.sv
